FILE: rtl/sdhr_pkg.sv
// ----------------------------------------------------------------------------
// sdhr_pkg: shared types and constants for the deadband tracker and heat ranker
// Holds field widths, reset values, the sort entry and the exact rank compare.
// ----------------------------------------------------------------------------
package sdhr_pkg;

  localparam int SLOT_W    = 2;
  localparam int MILLI_W   = 18;
  localparam int DEG_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_SLOTS = 4;
  localparam int NUM_W     = DEG_W + 1;
  localparam int DEN_W     = DEG_W;
  localparam int PROD_W    = NUM_W + DEN_W + 1;

  localparam int SENSORS_DEF  = 4;
  localparam int DEADBAND_DEF = 2;

  localparam logic [CFG_W-1:0] FLOOR_RESET = 8'd30;
  localparam logic [CFG_W-1:0] CEIL_RESET  = 8'd80;

  // Rounding to whole degrees: (m + 500) / 1000 as a reciprocal multiply.
  // 268436 / 2^28 is exact for every sum below 493000, which covers every
  // sum an 18-bit reading can produce.
  localparam int SUM_W       = MILLI_W + 1;
  localparam int RECIP_W     = 19;
  localparam int MUL_W       = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 28;
  localparam int QUOT_W      = MUL_W - RECIP_SHIFT;
  localparam logic [SUM_W-1:0]   ROUND_BIAS = 19'd500;
  localparam logic [RECIP_W-1:0] RECIP      = 19'd268436;
  localparam logic [QUOT_W-1:0]  DEG_MAX    = 10'd255;

  // One sensor travelling along the sort chain; position is num / den, den > 0.
  typedef struct packed {
    logic                     valid;
    logic [SLOT_W-1:0]        slot;
    logic [DEG_W-1:0]         deg;
    logic signed [NUM_W-1:0]  num;
    logic [DEN_W-1:0]         den;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } node_ctl_t;

  // True when a ranks before b: larger position, higher slot on a tie.
  function automatic logic ranks_before(entry_t a, entry_t b);
    logic signed [PROD_W-1:0] lhs;
    logic signed [PROD_W-1:0] rhs;
    lhs = PROD_W'(a.num) * PROD_W'($signed({1'b0, b.den}));
    rhs = PROD_W'(b.num) * PROD_W'($signed({1'b0, a.den}));
    return (lhs > rhs) || ((lhs == rhs) && (a.slot > b.slot));
  endfunction

endpackage

FILE: rtl/sdhr_cell.sv
// ----------------------------------------------------------------------------
// sdhr_cell: one stage of the systolic sort chain
// Keeps the best entry it has seen and hands the other one to its neighbor.
// During readout it takes the entry of its right neighbor instead.
// ----------------------------------------------------------------------------
module sdhr_cell
  import sdhr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  node_ctl_t ctl,
  input  entry_t    ins,
  input  entry_t    shift_in,
  output entry_t    held,
  output entry_t    pass
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held.valid <= 1'b0;
      pass.valid <= 1'b0;
    end else if (ctl.shift) begin
      held       <= shift_in;
      pass.valid <= 1'b0;
    end else if (ins.valid) begin
      // An empty stage forwards its invalid content, which is a bubble.
      if (!held.valid || ranks_before(ins, held)) begin
        held <= ins;
        pass <= held;
      end else begin
        pass <= ins;
      end
    end else begin
      pass.valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/sensor_deadband_and_heat_rank.sv
// ----------------------------------------------------------------------------
// sensor_deadband_and_heat_rank: deadband tracker and relative heat ranker
// Rounds millidegree readings per sensor slot; on end of scan updates the
// deadband references and emits the sensors sorted by position in range.
// ----------------------------------------------------------------------------
// A beat without tlast is stored and the block is ready again at once. A beat
// with tlast starts a scan pass: the feed state hands one sensor a cycle into
// a chain of SENSORS sort stages (deadband check on the way), the flush state
// lets the chain settle, then the drain state shifts the ranking out, one
// result beat a cycle when the sink is ready. The input is ready again once
// the drain state has loaded the last result beat, so output stalls delay it.
// Results carry rank position, slot and degrees in tdata, the any-changed
// flag in tuser and tlast on the final one.
// ----------------------------------------------------------------------------
module sensor_deadband_and_heat_rank
  import sdhr_pkg::*;
#(
  parameter int SENSORS  = SENSORS_DEF,
  parameter int DEADBAND = DEADBAND_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // [1:0] sensor_slot, [19:2] reading_milli
  input  logic                 s_tlast,   // end_of_scan
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [1:0] rank_position, [3:2] ranked_slot,
                                          // [11:4] ranked_degrees
  output logic                 m_tuser,   // any_changed
  output logic                 m_tlast,   // last_of_ranking
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SENSORS - 1);
  localparam int BAND_W = DEG_W + 2;
  localparam logic [BAND_W-1:0] BAND = BAND_W'(DEADBAND);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FEED  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             changed;

  logic [CFG_W-1:0] floor_reg [CFG_SLOTS];
  logic [CFG_W-1:0] ceil_reg  [CFG_SLOTS];
  logic [DEG_W-1:0] cur_deg   [SENSORS];
  logic [DEG_W-1:0] ref_deg   [SENSORS];

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CFG_SLOTS; k++) begin
        floor_reg[k] <= FLOOR_RESET;
        ceil_reg[k]  <= CEIL_RESET;
      end
    end else if (cfg_valid) begin
      if (cfg_index[0]) begin
        ceil_reg[cfg_index[CFG_IDX_W-1:1]]  <= cfg_data;
      end else begin
        floor_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------- input
  logic [SLOT_W-1:0]  in_slot;
  logic [MILLI_W-1:0] in_milli;
  logic [SUM_W-1:0]   round_sum;
  logic [MUL_W-1:0]   round_prod;
  logic [QUOT_W-1:0]  round_q;
  logic [DEG_W-1:0]   in_deg;
  logic               in_accept;
  logic               slot_ok;

  assign in_slot    = s_tdata[SLOT_W-1:0];
  assign in_milli   = s_tdata[SLOT_W+MILLI_W-1:SLOT_W];
  assign s_tready   = (state == ST_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign slot_ok    = int'(in_slot) < SENSORS;
  assign round_sum  = SUM_W'(in_milli) + ROUND_BIAS;
  assign round_prod = MUL_W'(round_sum) * MUL_W'(RECIP);
  assign round_q    = round_prod[MUL_W-1:RECIP_SHIFT];
  assign in_deg     = (round_q > DEG_MAX) ? DEG_MAX[DEG_W-1:0] : round_q[DEG_W-1:0];

  // ---------------------------------------------------------------- feed side
  logic [DEG_W-1:0]        f_cur;
  logic [DEG_W-1:0]        f_ref;
  logic [CFG_W-1:0]        f_lo;
  logic [CFG_W-1:0]        f_hi;
  logic signed [NUM_W-1:0] f_num_raw;
  logic signed [NUM_W-1:0] f_den_raw;
  logic                    f_out_band;
  entry_t                  feed_entry;

  assign f_cur     = cur_deg[cnt];
  assign f_ref     = ref_deg[cnt];
  assign f_lo      = floor_reg[SLOT_W'(cnt)];
  assign f_hi      = ceil_reg[SLOT_W'(cnt)];
  assign f_num_raw = $signed({1'b0, f_cur}) - $signed({1'b0, f_lo});
  assign f_den_raw = $signed({1'b0, f_hi}) - $signed({1'b0, f_lo});
  assign f_out_band = (BAND_W'(f_cur) + BAND < BAND_W'(f_ref)) ||
                      (BAND_W'(f_cur) > BAND_W'(f_ref) + BAND);

  always_comb begin
    feed_entry.valid = (state == ST_FEED);
    feed_entry.slot  = SLOT_W'(cnt);
    feed_entry.deg   = f_cur;
    if (f_den_raw == '0) begin
      feed_entry.num = f_num_raw;
      feed_entry.den = DEN_W'(1);
    end else if (f_den_raw < 0) begin
      // A reversed range flips the sign of both terms to keep den positive.
      feed_entry.num = -f_num_raw;
      feed_entry.den = DEN_W'(-f_den_raw);
    end else begin
      feed_entry.num = f_num_raw;
      feed_entry.den = f_den_raw[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SENSORS; k++) begin
        cur_deg[k] <= '0;
        ref_deg[k] <= '0;
      end
    end else begin
      if (in_accept && slot_ok) begin
        cur_deg[in_slot[CNT_W-1:0]] <= in_deg;
      end
      if (state == ST_FEED && f_out_band) begin
        ref_deg[cnt] <= f_cur;
      end
    end
  end

  // ---------------------------------------------------------------- sort chain
  entry_t    link [SENSORS+1];
  entry_t    hold [SENSORS+1];
  node_ctl_t ctl;
  logic      load;

  assign link[0]       = feed_entry;
  assign hold[SENSORS] = '0;
  assign load          = (state == ST_DRAIN) && (!m_tvalid || m_tready);
  assign ctl.clear     = in_accept && s_tlast;
  assign ctl.shift     = load;

  for (genvar g = 0; g < SENSORS; g++) begin : g_chain
    sdhr_cell u_stage (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .ins      (link[g]),
      .shift_in (hold[g+1]),
      .held     (hold[g]),
      .pass     (link[g+1])
    );
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      changed <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept && s_tlast) begin
            state   <= ST_FEED;
            cnt     <= '0;
            changed <= 1'b0;
          end
        end
        ST_FEED: begin
          if (f_out_band) begin
            changed <= 1'b1;
          end
          if (cnt == CNT_LAST) begin
            state <= ST_FLUSH;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (cnt == CNT_LAST) begin
            state <= ST_DRAIN;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (load) begin
            if (cnt == CNT_LAST) begin
              state <= ST_IDLE;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  logic [SLOT_W-1:0] out_pos;
  logic [SLOT_W-1:0] out_slot;
  logic [DEG_W-1:0]  out_deg;
  logic              out_chg;
  logic              out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pos  <= SLOT_W'(cnt);
      out_slot <= hold[0].slot;
      out_deg  <= hold[0].deg;
      out_chg  <= changed;
      out_last <= (cnt == CNT_LAST);
    end
  end

  assign m_tdata = {4'b0000, out_deg, out_slot, out_pos};
  assign m_tuser = out_chg;
  assign m_tlast = out_last;

  // ---------------------------------------------------------------- checks
  a_no_spill: assert property (@(posedge clk) disable iff (rst)
    !link[SENSORS].valid)
    else $error("sort chain pushed an entry off its end");

  a_head_full: assert property (@(posedge clk) disable iff (rst)
    load |-> hold[0].valid)
    else $error("readout took an empty head stage");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[1:0] == SLOT_W'(SENSORS - 1)))
    else $error("final result beat is not at the last rank position");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (state == ST_FEED))
    else $error("end-of-scan beat did not start a scan pass");

endmodule

FILE: tb/sv/tb_sensor_deadband_and_heat_rank.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_deadband_and_heat_rank: self-checking bench for the heat ranker
// Streams millidegree readings with random gaps and sink stalls, predicts the
// deadband updates and the ranking of every scan, and compares each result
// beat field by field. The range registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_sensor_deadband_and_heat_rank;
  import sdhr_pkg::*;

  localparam int NSENS       = SENSORS_DEF;
  localparam int BAND        = DEADBAND_DEF;
  localparam int FLOOR_OFS   = 0;
  localparam int CEIL_OFS    = 1;
  localparam int NREGS       = 2 * NSENS;
  localparam int SETTLE      = 3 * NSENS + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PAUSE   = 16;
  localparam int MAX_MILLI   = 2 ** MILLI_W - 1;

  typedef enum {SPAN_FULL, SPAN_ZERO, SPAN_REVERSED, SPAN_RANDOM, SPAN_MIXED} span_mode_t;

  typedef struct {
    logic [1:0]        position;
    logic [SLOT_W-1:0] slot;
    logic [DEG_W-1:0]  degrees;
    logic              changed;
    logic              last;
  } rank_beat_t;

  class heat_rank_scoreboard;
    logic [CFG_W-1:0] floor_deg[NSENS];
    logic [CFG_W-1:0] ceil_deg[NSENS];
    logic [DEG_W-1:0] now_deg[NSENS];
    logic [DEG_W-1:0] held_deg[NSENS];
    rank_beat_t       awaited_ranks[$];
    int               failures;

    function new();
      failures = 0;
      for (int s = 0; s < NSENS; s++) begin
        floor_deg[s] = FLOOR_RESET;
        ceil_deg[s]  = CEIL_RESET;
        now_deg[s]   = '0;
        held_deg[s]  = '0;
      end
    endfunction

    function void set_limit(int idx, logic [CFG_W-1:0] value);
      if (idx % 2 == FLOOR_OFS)
        floor_deg[idx / 2] = value;
      else
        ceil_deg[idx / 2] = value;
    endfunction

    // Position in range as num / den with den kept positive.
    function void span_of(int s, output int num, output int den);
      num = int'(now_deg[s]) - int'(floor_deg[s]);
      den = int'(ceil_deg[s]) - int'(floor_deg[s]);
      if (den == 0)
        den = 1;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
    endfunction

    function bit ranks_ahead(int a, int b);
      int na, da, nb, db;
      span_of(a, na, da);
      span_of(b, nb, db);
      if (na * db != nb * da)
        return na * db > nb * da;
      return a > b;
    endfunction

    function void note_reading(logic [SLOT_W-1:0] slot, logic [MILLI_W-1:0] milli,
                               logic scan_end);
      int         deg;
      int         place;
      bit         moved;
      int         order[NSENS];
      rank_beat_t beat;
      deg = (int'(milli) + 500) / 1000;
      if (int'(slot) < NSENS)
        now_deg[slot] = (deg > 255) ? 8'd255 : DEG_W'(deg);
      if (!scan_end)
        return;
      moved = 1'b0;
      for (int s = 0; s < NSENS; s++) begin
        if (int'(now_deg[s]) < int'(held_deg[s]) - BAND ||
            int'(now_deg[s]) > int'(held_deg[s]) + BAND) begin
          held_deg[s] = now_deg[s];
          moved = 1'b1;
        end
      end
      for (int i = 0; i < NSENS; i++) begin
        place = 0;
        for (int j = 0; j < NSENS; j++)
          if (j != i && ranks_ahead(j, i))
            place++;
        order[place] = i;
      end
      for (int p = 0; p < NSENS; p++) begin
        beat.position = 2'(p);
        beat.slot     = SLOT_W'(order[p]);
        beat.degrees  = now_deg[order[p]];
        beat.changed  = moved;
        beat.last     = (p == NSENS - 1);
        awaited_ranks.push_back(beat);
      end
    endfunction

    function void compare_field(string name, int expected_value, int actual_value);
      if (expected_value != actual_value) begin
        $error("%s: expected %0d, actual %0d", name, expected_value, actual_value);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] position, logic [SLOT_W-1:0] slot,
                               logic [DEG_W-1:0] degrees, logic changed, logic last);
      rank_beat_t want;
      if (awaited_ranks.size() == 0) begin
        $error("result beat with no ranking pending: position %0d slot %0d",
               position, slot);
        failures++;
        return;
      end
      want = awaited_ranks.pop_front();
      compare_field("rank_position", want.position, position);
      compare_field("ranked_slot", want.slot, slot);
      compare_field("ranked_degrees", want.degrees, degrees);
      compare_field("any_changed", want.changed, changed);
      compare_field("last_of_ranking", want.last, last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [15:0]          m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  heat_rank_scoreboard sb = new();
  int  cycle_count;
  bit  source_calm;
  bit  sink_calm;

  sensor_deadband_and_heat_rank uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    m_tready    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    cycle_count = 0;
    source_calm = 1'b0;
    sink_calm   = 1'b0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sensor_deadband_and_heat_rank: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_reading(s_tdata[1:0], s_tdata[19:2], s_tlast);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[1:0], m_tdata[3:2], m_tdata[11:4], m_tuser, m_tlast);
  end

  function automatic int pause_draw(bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_PAUSE));
  endfunction

  // The sink stalls before every beat; a zero stall keeps tready high.
  initial begin : result_sink
    int stall;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 11) == 0)
        sink_calm = ~sink_calm;
      stall = pause_draw(sink_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_reading(input int slot, input int milli, input bit scan_end);
    int gap;
    if ($urandom_range(0, 9) == 0)
      source_calm = ~source_calm;
    gap = pause_draw(source_calm);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, MILLI_W'(milli), SLOT_W'(slot)};
    s_tlast  <= scan_end;
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits until every ranking has come out and the block has gone quiet.
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.awaited_ranks.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_ranges(input span_mode_t mode);
    logic [CFG_W-1:0] limits[NREGS];
    int               pick;
    int               v;
    for (int s = 0; s < NSENS; s++) begin
      pick = (mode == SPAN_MIXED) ? int'($urandom_range(SPAN_FULL, SPAN_RANDOM)) : mode;
      case (pick)
        SPAN_FULL: begin
          limits[2*s + FLOOR_OFS] = 8'd0;
          limits[2*s + CEIL_OFS]  = 8'd255;
        end
        SPAN_ZERO: begin
          v = (s == 0) ? 0 : (s == 1) ? 255 : int'($urandom_range(0, 255));
          limits[2*s + FLOOR_OFS] = CFG_W'(v);
          limits[2*s + CEIL_OFS]  = CFG_W'(v);
        end
        SPAN_REVERSED: begin
          v = (s == 0) ? 0 : int'($urandom_range(0, 254));
          limits[2*s + FLOOR_OFS] = 8'd255;
          limits[2*s + CEIL_OFS]  = CFG_W'(v);
          if (s > 1)
            limits[2*s + FLOOR_OFS] = CFG_W'($urandom_range(v + 1, 255));
        end
        default: begin
          limits[2*s + FLOOR_OFS] = CFG_W'($urandom_range(0, 255));
          limits[2*s + CEIL_OFS]  = CFG_W'($urandom_range(0, 255));
        end
      endcase
    end
    for (int r = 0; r < NREGS; r++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= limits[r];
      do @(posedge clk); while (!cfg_ready);
      sb.set_limit(r, limits[r]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly readings close to the slot's current value so the deadband edge
  // is hit often; now and then anything the field can carry.
  function automatic int pick_reading(int slot);
    int deg;
    int milli;
    if ($urandom_range(0, 3) == 0)
      return int'($urandom_range(0, MAX_MILLI));
    deg = int'(sb.now_deg[slot]) + int'($urandom_range(0, 8)) - 4;
    deg = (deg < 0) ? 0 : (deg > 255) ? 255 : deg;
    milli = deg * 1000 + int'($urandom_range(0, 999)) - 500;
    return (milli < 0) ? 0 : milli;
  endfunction

  initial begin : stimulus
    int slot;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Rounding edges and saturation, with reset ranges.
    send_reading(0, 0, 1'b0);
    send_reading(1, 499, 1'b0);
    send_reading(2, 500, 1'b0);
    send_reading(3, MAX_MILLI, 1'b1);
    send_reading(0, 255499, 1'b0);
    send_reading(1, 255500, 1'b1);
    send_reading(2, 2499, 1'b1);
    // All equal: ties go to the higher slot.
    for (int s = 0; s < NSENS; s++)
      send_reading(s, 50000, s == NSENS - 1);
    // Just inside and just outside the deadband, both directions.
    send_reading(0, 52000, 1'b1);
    send_reading(0, 53000, 1'b1);
    send_reading(1, 48000, 1'b1);
    send_reading(1, 47000, 1'b1);
    send_reading(3, 0, 1'b0);
    send_reading(2, 131072, 1'b1);
    wait_quiet();

    for (int m = SPAN_FULL; m <= SPAN_MIXED; m++) begin
      program_ranges(span_mode_t'(m));
      for (int k = 0; k < 16; k++) begin
        slot = int'($urandom_range(0, NSENS - 1));
        send_reading(slot, pick_reading(slot), $urandom_range(0, 2) == 0);
      end
      send_reading(int'($urandom_range(0, NSENS - 1)), int'($urandom_range(0, 255499)), 1'b1);
      wait_quiet();
    end

    if (sb.failures == 0)
      $display("sensor_deadband_and_heat_rank: match");
    else
      $display("sensor_deadband_and_heat_rank: mismatch");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sdhr_pkg.sv
rtl/sdhr_cell.sv
rtl/sensor_deadband_and_heat_rank.sv
tb/sv/tb_sensor_deadband_and_heat_rank.sv
